// ----- src/fit_policy_block_allocator_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/fpba_pkg.sv -----
// Package with types, codes and constants of the fit policy block allocator.
`default_nettype none
package fpba_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int IDX_W     = 4;
    localparam int SZ_W      = 16;
    localparam int POLICY_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int PAD_W     = S_TDATA_W - IDX_W - SZ_W;
    localparam int M_TUSER_W = 2;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [COUNT_W-1:0] SCAN_MAX = 5'd16;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic REG_FIT_POLICY    = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam logic [POLICY_W-1:0] FIT_POLICY_RST    = POLICY_FIRST;
    localparam logic [COUNT_W-1:0]  BLOCKS_IN_USE_RST = 5'd16;

    typedef struct packed {
        logic [POLICY_W-1:0] fit_policy;
        logic [COUNT_W-1:0]  blocks_in_use;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- src/fpba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- src/fpba_regs.sv -----
// APB configuration registers: placement policy and search count.
`default_nettype none
module fpba_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpba_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fpba_pkg::APB_DW-1:0]   pwdata,
    output logic      [fpba_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output fpba_pkg::cfg_t                     cfg
);
    logic [fpba_pkg::POLICY_W-1:0] fit_policy_reg;
    logic [fpba_pkg::COUNT_W-1:0]  blocks_in_use_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg    <= fpba_pkg::FIT_POLICY_RST;
            blocks_in_use_reg <= fpba_pkg::BLOCKS_IN_USE_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                fpba_pkg::REG_FIT_POLICY:
                begin
                    fit_policy_reg <= pwdata[fpba_pkg::POLICY_W-1:0];
                end
                fpba_pkg::REG_BLOCKS_IN_USE:
                begin
                    blocks_in_use_reg <= pwdata[fpba_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    fit_policy_reg <= fit_policy_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            fpba_pkg::REG_FIT_POLICY:
                prdata = fpba_pkg::APB_DW'(fit_policy_reg);
            fpba_pkg::REG_BLOCKS_IN_USE:
                prdata = fpba_pkg::APB_DW'(blocks_in_use_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.fit_policy    = fit_policy_reg;
    assign cfg.blocks_in_use = blocks_in_use_reg;

endmodule
`default_nettype wire

// ----- src/fpba_ctrl.sv -----
// Sequencer: loads entries, scans the free-size memory and writes back the chosen block.
`default_nettype none
`include "fit_policy_block_allocator_macros.svh"
module fpba_ctrl #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fpba_pkg::cfg_t                   cfg,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fpba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [0:0]                       s_tuser,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [fpba_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [fpba_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                  m_tlast,
    output logic                                  ram_we,
    output logic      [AW-1:0]                    ram_waddr,
    output logic      [SIZE_BITS-1:0]             ram_wdata,
    output logic                                  ram_re,
    output logic      [AW-1:0]                    ram_raddr,
    input  wire logic [SIZE_BITS-1:0]             ram_rdata
);
    localparam int IW = fpba_pkg::IDX_W;
    localparam int CW = fpba_pkg::COUNT_W;
    localparam logic [CW-1:0] MB_CAP =
        (MAX_BLOCKS < 16) ? CW'(MAX_BLOCKS) : fpba_pkg::SCAN_MAX;

    fpba_pkg::state_t state_reg, state_next;

    logic                           op_reg, op_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [SIZE_BITS-1:0]           size_reg, size_next;
    logic                           last_reg, last_next;
    logic [IW-1:0]                  rcnt_reg, rcnt_next;
    logic                           found_reg, found_next;
    logic [IW-1:0]                  best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]           best_val_reg, best_val_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [fpba_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [fpba_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic                           s_accept;
    logic                           req_scan;
    logic                           out_free;
    logic                           out_load;
    logic [CW-1:0]                  n_cfg;
    logic [CW-1:0]                  n_search;
    logic                           fits;
    logic                           is_best;
    logic                           is_worst;
    logic                           take;
    logic                           first_hit;
    logic                           scan_last;
    logic                           idx_in_range;
    logic                           granted;
    logic [SIZE_BITS-1:0]           remain;

    assign s_accept = s_tvalid & s_tready;
    assign req_scan = s_accept & (s_tuser[0] == fpba_pkg::OP_REQUEST) & (n_search != '0);
    assign out_free = ~m_tvalid_reg | m_tready;
    assign out_load = (state_reg == fpba_pkg::ST_DONE) & out_free;

    assign n_cfg    = (cfg.blocks_in_use > fpba_pkg::SCAN_MAX) ? fpba_pkg::SCAN_MAX
                                                                : cfg.blocks_in_use;
    assign n_search = (n_cfg > MB_CAP) ? MB_CAP : n_cfg;

    assign is_best   = (cfg.fit_policy == fpba_pkg::POLICY_BEST);
    assign is_worst  = (cfg.fit_policy == fpba_pkg::POLICY_WORST);
    assign fits      = (ram_rdata >= size_reg);
    assign take      = fits & (~found_reg | (is_best & (ram_rdata < best_val_reg))
                                          | (is_worst & (ram_rdata > best_val_reg)));
    assign first_hit = fits & ~found_reg & ~is_best & ~is_worst;
    assign scan_last = ({1'b0, rcnt_reg} == (n_search - CW'(1))) | first_hit;

    assign idx_in_range = (32'(idx_reg) < 32'(MAX_BLOCKS));
    assign granted      = (op_reg == fpba_pkg::OP_REQUEST) & found_reg;
    assign remain       = best_val_reg - size_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (req_scan)
                        state_next = fpba_pkg::ST_SCAN;
                    else
                        state_next = fpba_pkg::ST_DONE;
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = fpba_pkg::ST_DONE;
            end
            fpba_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = fpba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = (op_reg == fpba_pkg::OP_LOAD) ? AW'(idx_reg) : AW'(best_idx_reg);
        ram_wdata = (op_reg == fpba_pkg::OP_LOAD) ? size_reg : remain;
        case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                ram_re   = s_tvalid & (s_tuser[0] == fpba_pkg::OP_REQUEST);
            end
            fpba_pkg::ST_SCAN:
            begin
                ram_re    = ~scan_last;
                ram_raddr = AW'(IW'(rcnt_reg + IW'(1)));
            end
            fpba_pkg::ST_DONE:
            begin
                ram_we = out_free & ((op_reg == fpba_pkg::OP_LOAD) ? idx_in_range : found_reg);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        idx_next      = idx_reg;
        size_next     = size_reg;
        last_next     = last_reg;
        rcnt_next     = rcnt_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        if (s_accept)
        begin
            op_next       = s_tuser[0];
            idx_next      = s_tdata[IW-1:0];
            size_next     = SIZE_BITS'(s_tdata[IW +: fpba_pkg::SZ_W]);
            last_next     = s_tlast;
            rcnt_next     = '0;
            found_next    = 1'b0;
            best_idx_next = '0;
            best_val_next = '0;
        end
        else if (state_reg == fpba_pkg::ST_SCAN)
        begin
            rcnt_next = rcnt_reg + IW'(1);
            if (take)
            begin
                found_next    = 1'b1;
                best_idx_next = rcnt_reg;
                best_val_next = ram_rdata;
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{fpba_pkg::PAD_W{1'b0}},
                             granted ? fpba_pkg::SZ_W'(remain) : {fpba_pkg::SZ_W{1'b0}},
                             granted ? best_idx_reg : {IW{1'b0}}};
            m_tuser_next  = {(op_reg == fpba_pkg::OP_LOAD), granted};
            m_tlast_next  = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fpba_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        size_reg     <= size_next;
        last_reg     <= last_next;
        rcnt_reg     <= rcnt_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_IMPLY(a_scan_in_range, state_reg == fpba_pkg::ST_SCAN, {1'b0, rcnt_reg} < n_search)
    `ASSERT_NEXT(a_req_scans, req_scan, state_reg == fpba_pkg::ST_SCAN)
    `ASSERT_IMPLY(a_found_fits, found_reg && state_reg != fpba_pkg::ST_IDLE, best_val_reg >= size_reg)
    `ASSERT_IMPLY(a_result_from_done, $rose(m_tvalid_reg), $past(state_reg) == fpba_pkg::ST_DONE)

endmodule
`default_nettype wire

// ----- src/fit_policy_block_allocator.sv -----
// Top level of the fit policy block allocator.
//
// Input channel s_*: each item either loads the free size of one block
// (s_tuser opcode 0) or requests an allocation (opcode 1). Output channel m_*
// returns exactly one result item per input item, in order.
// The APB port sets the placement rule (first, best or worst fit) and the
// number of blocks searched; write it only while the block is idle.
// A load goes from idle straight to the done state. A request first reads
// the free-size memory once for each block searched, one read per cycle,
// then the done state writes back the chosen block and loads the output
// register once it is free. First fit stops at the first hit.
// One item is in flight at a time and the next item is accepted in the
// idle state that follows the done state.
// The memory holds no reset value; a request must only scan loaded blocks.
// Reset idles the sequencer, clears m_tvalid, sets first fit and 16 blocks.
// When the receiver stalls, the result holds in the output register; the next
// item is accepted once the block is back in idle.
`default_nettype none
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [3:0] load_index, [19:4] size_value, [23:20] zero
    input  wire logic [fpba_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] opcode
    input  wire logic [0:0]                       s_tuser,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [3:0] chosen_block, [19:4] remaining_free, [23:20] zero
    output logic      [fpba_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] granted, [1] was_load
    output logic      [fpba_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                  m_tlast,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fpba_pkg::APB_AW-1:0]      paddr,
    input  wire logic [fpba_pkg::APB_DW-1:0]      pwdata,
    output logic      [fpba_pkg::APB_DW-1:0]      prdata,
    output logic                                  pready
);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    fpba_pkg::cfg_t       cfg;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    fpba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule
`default_nettype wire
